// ----- sv/rbcl_pkg.sv -----
// ----------------------------------------------------------------------------
// rbcl_pkg : shared types and constants of the ray box chord length block
// Widths, pipeline lengths, register codes and a small helper function.
// ----------------------------------------------------------------------------
package rbcl_pkg;

    localparam int POS_W       = 48;               // origin, Q31.16
    localparam int DIR_W       = 32;               // direction, Q1.30
    localparam int DIR_FRAC    = 30;
    localparam int CFG_W       = 47;               // configuration registers
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_W       = POS_W + 2;        // bound minus origin
    localparam int T_W         = 64;               // ray parameter
    localparam int OUT_W       = 48;               // output fields

    // Divider: quotient bits 62 down to 0, one bit per stage.
    localparam int DIV_Q_BITS  = 63;
    localparam int DIV_MB_W    = DIV_Q_BITS - DIR_FRAC;   // numerator bits fed in
    localparam int DIV_HI_W    = NUM_W - DIV_MB_W;        // bits above bit 62
    localparam int DIV_LAT     = DIV_Q_BITS + 2;

    // Square root of the squared direction length, one result bit per stage.
    localparam int SQ_W        = 64;
    localparam int LEN_W       = 32;
    localparam int ISQRT_STEPS = LEN_W;
    localparam int ISQRT_LAT   = DIV_LAT + 4;
    localparam int ISQRT_DLY   = ISQRT_LAT - 2 - ISQRT_STEPS;

    localparam int CHORD_LAT   = 5;
    localparam int PIPE_LAT    = 2 + DIV_LAT + CHORD_LAT;

    localparam logic signed [T_W-1:0] T_LIMIT = 64'sd4611686018427387904;  // 2^62
    localparam logic signed [T_W-1:0] S48_MAX = 64'sd140737488355327;
    localparam logic signed [T_W-1:0] S48_MIN = -64'sd140737488355328;

    localparam logic [CFG_W-1:0] HALF_RESET = 47'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_CENTER = 1'b0,
        CFG_BOX_HALF   = 1'b1
    } cfg_reg_t;

    // Per-ray flags carried alongside the dividers.
    typedef struct packed {
        logic pre_miss;
        logic par_y;
        logic par_z;
    } side_t;

    typedef struct packed {
        logic                    hit;
        logic        [OUT_W-1:0] chord;
        logic signed [OUT_W-1:0] entry;
        logic signed [OUT_W-1:0] exit_p;
    } result_t;

    function automatic logic signed [OUT_W-1:0] sat48(input logic signed [T_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > S48_MAX) begin
            r = S48_MAX[OUT_W-1:0];
        end else if (v < S48_MIN) begin
            r = S48_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/rbcl_slab_div.sv -----
// ----------------------------------------------------------------------------
// rbcl_slab_div : pipelined slab divider
// Computes (num * 2^30) / den truncated toward zero, magnitude clamped to 2^62.
// ----------------------------------------------------------------------------
module rbcl_slab_div
    import rbcl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DIR_W-1:0] den,
    output logic signed [T_W-1:0]   t
);

    logic [NUM_W-1:0]    mag;
    logic [DIR_W-1:0]    dv;
    logic [DIV_HI_W-1:0] hi;

    logic [DIR_W-1:0]      rem_reg [DIV_Q_BITS+1];
    logic [DIR_W-1:0]      dv_reg  [DIV_Q_BITS+1];
    logic [DIV_MB_W-1:0]   mb_reg  [DIV_Q_BITS+1];
    logic [DIV_Q_BITS-1:0] q_reg   [DIV_Q_BITS+1];
    logic                  neg_reg [DIV_Q_BITS+1];
    logic                  ovf_reg [DIV_Q_BITS+1];

    logic [T_W-1:0] qc;

    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dv  = den[DIR_W-1] ? DIR_W'(-den) : DIR_W'(den);
    assign hi  = mag[NUM_W-1:DIV_MB_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DIR_W'(hi);
            dv_reg[0]  <= dv;
            mb_reg[0]  <= mag[DIV_MB_W-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DIR_W-1];
            // A quotient of 2^63 or more is clamped anyway.
            ovf_reg[0] <= (DIR_W'(hi) >= dv);
        end
    end

    for (genvar j = 1; j <= DIV_Q_BITS; j++) begin : g_step
        logic [DIR_W:0] r2;
        logic [DIR_W:0] diff;
        logic           ge;

        assign r2   = {rem_reg[j-1], mb_reg[j-1][DIV_MB_W-1]};
        assign diff = r2 - {1'b0, dv_reg[j-1]};
        assign ge   = (r2 >= {1'b0, dv_reg[j-1]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? diff[DIR_W-1:0] : r2[DIR_W-1:0];
                dv_reg[j]  <= dv_reg[j-1];
                mb_reg[j]  <= {mb_reg[j-1][DIV_MB_W-2:0], 1'b0};
                q_reg[j]   <= {q_reg[j-1][DIV_Q_BITS-2:0], ge};
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    always_comb begin
        if (ovf_reg[DIV_Q_BITS] || (T_W'(q_reg[DIV_Q_BITS]) > T_W'(T_LIMIT))) begin
            qc = T_W'(T_LIMIT);
        end else begin
            qc = T_W'(q_reg[DIV_Q_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t <= neg_reg[DIV_Q_BITS] ? $signed(-qc) : $signed(qc);
        end
    end

endmodule

// ----- sv/rbcl_isqrt.sv -----
// ----------------------------------------------------------------------------
// rbcl_isqrt : direction length unit
// Squares and sums the direction, takes the integer square root one bit per
// stage, then delays the result to line up with the slab dividers.
// ----------------------------------------------------------------------------
module rbcl_isqrt
    import rbcl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [DIR_W-1:0] dx,
    input  logic signed [DIR_W-1:0] dy,
    input  logic signed [DIR_W-1:0] dz,
    output logic        [LEN_W-1:0] len
);

    logic signed [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic        [SQ_W-1:0] v_reg    [ISQRT_STEPS+1];
    logic        [LEN_W+2:0] rem_reg [ISQRT_STEPS+1];
    logic        [LEN_W-1:0] root_reg [ISQRT_STEPS+1];
    logic        [LEN_W-1:0] dly_reg  [ISQRT_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg     <= dx * dx;
            sqy_reg     <= dy * dy;
            sqz_reg     <= dz * dz;
            v_reg[0]    <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 1; i <= ISQRT_STEPS; i++) begin : g_step
        logic [LEN_W+2:0] r;
        logic [LEN_W+2:0] trial;
        logic             ge;

        assign r     = {rem_reg[i-1][LEN_W:0], v_reg[i-1][SQ_W-1:SQ_W-2]};
        assign trial = {1'b0, root_reg[i-1], 2'b01};
        assign ge    = (r >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? (r - trial) : r;
                root_reg[i] <= {root_reg[i-1][LEN_W-2:0], ge};
                v_reg[i]    <= {v_reg[i-1][SQ_W-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= root_reg[ISQRT_STEPS];
            for (int k = 1; k < ISQRT_DLY; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign len = dly_reg[ISQRT_DLY-1];

endmodule

// ----- sv/rbcl_chord.sv -----
// ----------------------------------------------------------------------------
// rbcl_chord : slab intersection and chord length
// Orders each slab interval, intersects the three, checks for a miss and
// scales the parameter span by the direction length.
// ----------------------------------------------------------------------------
module rbcl_chord
    import rbcl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [T_W-1:0] t_a [3],
    input  logic signed [T_W-1:0] t_b [3],
    input  side_t                 side,
    input  logic [LEN_W-1:0]      len,
    output result_t               res
);

    logic signed [T_W-1:0] lo_reg [3];
    logic signed [T_W-1:0] hi_reg [3];
    logic                  miss1_reg;
    logic signed [T_W-1:0] entry_reg, exit_reg;
    logic                  miss2_reg;
    logic                  ok3_reg;
    logic [T_W-1:0]        diff_reg;
    logic signed [T_W-1:0] entry3_reg, exit3_reg;
    logic                  ok4_reg;
    logic [2*LEN_W-1:0]    a_reg, b_reg;
    logic signed [OUT_W-1:0] entry4_reg, exit4_reg;

    logic                  par [3];
    logic signed [T_W-1:0] mx01, mn01, mx, mn;
    logic [OUT_W:0]        sum;
    logic [OUT_W-1:0]      chord;

    assign par[0] = 1'b0;
    assign par[1] = side.par_y;
    assign par[2] = side.par_z;

    // Stage 1: order each interval; a parallel slab spans the whole range.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (par[k]) begin
                    lo_reg[k] <= -T_LIMIT;
                    hi_reg[k] <= T_LIMIT;
                end else if (t_a[k] > t_b[k]) begin
                    lo_reg[k] <= t_b[k];
                    hi_reg[k] <= t_a[k];
                end else begin
                    lo_reg[k] <= t_a[k];
                    hi_reg[k] <= t_b[k];
                end
            end
            miss1_reg <= side.pre_miss;
        end
    end

    // Stage 2: entry is the largest lower bound, exit the smallest upper one.
    assign mx01 = (lo_reg[0] > lo_reg[1]) ? lo_reg[0] : lo_reg[1];
    assign mx   = (mx01 > lo_reg[2]) ? mx01 : lo_reg[2];
    assign mn01 = (hi_reg[0] < hi_reg[1]) ? hi_reg[0] : hi_reg[1];
    assign mn   = (mn01 < hi_reg[2]) ? mn01 : hi_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg <= mx;
            exit_reg  <= mn;
            miss2_reg <= miss1_reg;
        end
    end

    // Stage 3: miss on disjoint slabs, negative entry or exit, or pre_miss.
    always_ff @(posedge aclk) begin
        if (en) begin
            ok3_reg    <= !miss2_reg && (entry_reg <= exit_reg) &&
                          !entry_reg[T_W-1] && !exit_reg[T_W-1];
            diff_reg   <= T_W'(exit_reg) - T_W'(entry_reg);
            entry3_reg <= entry_reg;
            exit3_reg  <= exit_reg;
        end
    end

    // Stage 4: two 32 by 32 partial products of length times span.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg      <= len * diff_reg[LEN_W-1:0];
            b_reg      <= len * diff_reg[T_W-1:LEN_W];
            ok4_reg    <= ok3_reg;
            entry4_reg <= sat48(entry3_reg);
            exit4_reg  <= sat48(exit3_reg);
        end
    end

    // Stage 5: recombine, drop the fraction bits and saturate; a miss or zero chord clears all fields.
    assign sum = {1'b0, b_reg[OUT_W-3:0], 2'b00} +
                 (OUT_W+1)'(a_reg[2*LEN_W-1:DIR_FRAC]);

    always_comb begin
        if ((b_reg[2*LEN_W-1:OUT_W-2] != '0) || sum[OUT_W]) begin
            chord = '1;
        end else begin
            chord = sum[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res.hit    <= ok4_reg && (chord != '0);
            res.chord  <= (ok4_reg && (chord != '0)) ? chord : '0;
            res.entry  <= (ok4_reg && (chord != '0)) ? entry4_reg : '0;
            res.exit_p <= (ok4_reg && (chord != '0)) ? exit4_reg : '0;
        end
    end

endmodule

// ----- sv/ray_box_chord_length.sv -----
// ----------------------------------------------------------------------------
// ray_box_chord_length : ray against cube, slab method, chord length
// Tests one ray per cycle while not stalled against a cube centred on the x
// axis; reports the chord length inside it with entry and exit parameters.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   ray origin and direction
//  m_        out        m_tvalid / m_tready   hit flag, chord, entry, exit
//  cfg_      in         cfg_valid / cfg_ready register index and value
//
// One ray is taken per cycle while s_tready is high; each result waits in
// the output register until it transfers out. Most of the pipeline is the
// 63 one-bit stages of the slab dividers.
// Reset is synchronous and active low; it empties the pipeline and loads
// the cube registers with centre 0 and half edge 1.0.
// The pipeline advances as a whole. An output register with a skid stage
// behind it keeps taking rays while a result waits; only once the skid stage
// is full does s_tready fall, driven straight from the skid valid register.
//
module ray_box_chord_length
    import rbcl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x [47:0], origin_y [95:48], origin_z [143:96],
    // dir_x [175:144], dir_y [207:176], dir_z [239:208]
    input  logic [239:0]         s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // chord_length [47:0], entry_param [95:48], exit_param [143:96]
    output logic [143:0]         m_tdata,
    // hit [0]
    output logic [0:0]           m_tuser,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Cube registers.
    logic [CFG_W-1:0] center_reg, half_reg;

    // The pipeline moves whenever the skid stage is empty.
    logic adv;
    logic [PIPE_LAT-1:0] vld_reg;

    // First stage: the ray as it came in.
    logic signed [POS_W-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [DIR_W-1:0] dx_reg, dy_reg, dz_reg;

    // Second stage: slab numerators and early miss flags.
    logic signed [NUM_W-1:0] c_ext, h_ext, ox_ext, oy_ext, oz_ext;
    logic signed [NUM_W-1:0] n_lo [3];
    logic signed [NUM_W-1:0] n_hi [3];
    logic signed [NUM_W-1:0] n_lo_reg [3];
    logic signed [NUM_W-1:0] n_hi_reg [3];
    logic signed [DIR_W-1:0] d_reg [3];
    logic                    in_y, in_z;
    side_t                   side_next;
    side_t                   side_reg [DIV_LAT+1];

    logic signed [T_W-1:0] t_a [3];
    logic signed [T_W-1:0] t_b [3];
    logic [LEN_W-1:0]      len;
    result_t               pipe_res;

    // Output register and skid stage.
    result_t out_reg, skid_reg;
    logic    out_vld_reg, skid_vld_reg;
    logic    push, pop;

    // ------------------------------------------------------------------
    // Configuration: always ready; the user keeps it written only while the block is idle (not enforced).
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            half_reg   <= HALF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BOX_CENTER: center_reg <= cfg_data;
                CFG_BOX_HALF:   half_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel down the pipeline with the data.
    // ------------------------------------------------------------------
    assign adv      = !skid_vld_reg;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg <= s_tdata[47:0];
            oy_reg <= s_tdata[95:48];
            oz_reg <= s_tdata[143:96];
            dx_reg <= s_tdata[175:144];
            dy_reg <= s_tdata[207:176];
            dz_reg <= s_tdata[239:208];
        end
    end

    // ------------------------------------------------------------------
    // Slab bounds minus origin. The x slab is [c-h, c+h], the y and z
    // slabs are [-h, h]. A parallel slab holds the ray only when both
    // numerators straddle zero, bounds included.
    // ------------------------------------------------------------------
    assign c_ext  = $signed({3'b000, center_reg});
    assign h_ext  = $signed({3'b000, half_reg});
    assign ox_ext = $signed({{2{ox_reg[POS_W-1]}}, ox_reg});
    assign oy_ext = $signed({{2{oy_reg[POS_W-1]}}, oy_reg});
    assign oz_ext = $signed({{2{oz_reg[POS_W-1]}}, oz_reg});

    assign n_lo[0] = c_ext - h_ext - ox_ext;
    assign n_hi[0] = c_ext + h_ext - ox_ext;
    assign n_lo[1] = -h_ext - oy_ext;
    assign n_hi[1] = h_ext - oy_ext;
    assign n_lo[2] = -h_ext - oz_ext;
    assign n_hi[2] = h_ext - oz_ext;

    assign in_y = (n_lo[1][NUM_W-1] || (n_lo[1] == '0)) && !n_hi[1][NUM_W-1];
    assign in_z = (n_lo[2][NUM_W-1] || (n_lo[2] == '0)) && !n_hi[2][NUM_W-1];

    // A ray must head towards positive x and the cube must sit off the
    // origin; a parallel slab the ray lies outside of is a miss as well.
    assign side_next.pre_miss = dx_reg[DIR_W-1] || (dx_reg == '0) ||
                                (center_reg == '0) ||
                                ((dy_reg == '0) && !in_y) ||
                                ((dz_reg == '0) && !in_z);
    assign side_next.par_y    = (dy_reg == '0);
    assign side_next.par_z    = (dz_reg == '0);

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                n_lo_reg[k] <= n_lo[k];
                n_hi_reg[k] <= n_hi[k];
            end
            d_reg[0]    <= dx_reg;
            d_reg[1]    <= dy_reg;
            d_reg[2]    <= dz_reg;
            side_reg[0] <= side_next;
            for (int k = 1; k <= DIV_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Six dividers give both slab parameters of every axis.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 3; k++) begin : g_axis
        rbcl_slab_div u_div_lo (
            .aclk (aclk),
            .en   (adv),
            .num  (n_lo_reg[k]),
            .den  (d_reg[k]),
            .t    (t_a[k])
        );

        rbcl_slab_div u_div_hi (
            .aclk (aclk),
            .en   (adv),
            .num  (n_hi_reg[k]),
            .den  (d_reg[k]),
            .t    (t_b[k])
        );
    end

    // The direction length runs beside the dividers and arrives just in
    // time for the chord multiply.
    rbcl_isqrt u_isqrt (
        .aclk (aclk),
        .en   (adv),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .dz   (dz_reg),
        .len  (len)
    );

    rbcl_chord u_chord (
        .aclk (aclk),
        .en   (adv),
        .t_a  (t_a),
        .t_b  (t_b),
        .side (side_reg[DIV_LAT]),
        .len  (len),
        .res  (pipe_res)
    );

    // ------------------------------------------------------------------
    // Output register with skid stage. A result leaving the pipeline goes
    // to the output register when it is free or being taken, otherwise to
    // the skid stage, which then holds the pipeline.
    // ------------------------------------------------------------------
    assign push = adv && vld_reg[PIPE_LAT-1];
    assign pop  = out_vld_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_reg <= pipe_res;
            end else begin
                skid_reg <= pipe_res;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {out_reg.exit_p, out_reg.entry, out_reg.chord};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage holds a result while the output is empty");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved during a stall");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss carries non-zero fields");

    a_hit_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata[47:0] != '0) && !m_tdata[95] &&
                                      !m_tdata[143] &&
                                      (m_tdata[95:48] <= m_tdata[143:96])))
        else $error("hit with empty chord or bad parameters");

endmodule
